[rtl/core/lcfd_pkg.sv]
// lcfd_pkg: shared constants and types for the length checked frame deframer
// no dependencies

package lcfd_pkg;

    localparam int BUF_BYTES_DEF   = 64;
    localparam int PAYLOAD_MAX_DEF = 32;
    localparam int MAX_RESULTS     = 60;
    localparam int NRES_W          = 6;

    localparam logic [7:0] CPL_MASK    = 8'hFF;
    localparam logic [7:0] MIN_LEN     = 8'd5;
    localparam logic [7:0] HDR_CHK_LEN = 8'd4;
    localparam logic [7:0] LEN_OFS     = 8'd1;
    localparam logic [7:0] NLEN_OFS    = 8'd2;
    localparam logic [7:0] CMD_OFS     = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_SUM,
        ST_SUM_END,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } lcfd_state_t;

endpackage

[rtl/core/lcfd_ram.sv]
// lcfd_ram: generic single write, single read ram with registered read
// no dependencies

module lcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/length_checked_frame_deframer.sv]
// length_checked_frame_deframer: top level, window memory and scan sequencer
// depends on lcfd_pkg and lcfd_ram

// Received bytes go into a circular window held in one ram. After each byte the
// sequencer scans the window head: it reads and tests the header, sums a
// candidate of length L through the single read port, and delivers each payload
// byte by read, load and hand over. A bad header or checksum drops one byte and
// the scan restarts. The scan ends without a header test while fewer than three
// bytes are held. in_stall stays high until the scan is done. No clearing pass
// is needed after reset.

module length_checked_frame_deframer #(
    parameter int BUF_BYTES   = lcfd_pkg::BUF_BYTES_DEF,
    parameter int PAYLOAD_MAX = lcfd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_addr,
    output logic [6:0] frame_len,
    output logic [5:0] payload_len,
    output logic [4:0] byte_index,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_check,
    output logic       truncated,
    output logic       last_of_frame
);

    import lcfd_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam logic [8:0] BUF9 = 9'(BUF_BYTES);
    localparam logic [7:0] BUF8 = 8'(BUF_BYTES);
    localparam logic [7:0] PMAX8 = 8'(PAYLOAD_MAX);
    localparam logic [NRES_W-1:0] NRES_MAX = NRES_W'(MAX_RESULTS);

    lcfd_state_t state_reg, state_next;

    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [7:0]        len_reg;
    logic [7:0]        idx_reg;
    logic [7:0]        pidx_reg;
    logic              pend_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        addr_reg;
    logic [7:0]        chk_reg;
    logic [7:0]        k_reg;
    logic [NRES_W-1:0] nres_reg;
    logic              out_valid_reg;

    logic [7:0] ofrm_addr_reg, ofrm_chk_reg, obyte_reg;
    logic [6:0] olen_reg;
    logic [5:0] ocap_reg;
    logic [4:0] oidx_reg;
    logic       otrunc_reg, olast_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_ofs;

    logic       in_acc, out_acc;
    logic       hdr_bad, short_win, chk_bad, last_k;
    logic [7:0] total, cap;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base, input logic [7:0] ofs);
        logic [8:0] s;
        s = 9'(base) + 9'(ofs);
        if (s >= BUF9)
        begin
            s = s - BUF9;
        end
        return s[AW-1:0];
    endfunction

    lcfd_ram #(
        .WIDTH(8),
        .DEPTH(BUF_BYTES)
    ) u_win_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(rx_data),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign total     = len_reg - HDR_CHK_LEN;
    assign cap       = (total > PMAX8) ? PMAX8 : total;
    assign last_k    = (k_reg + 8'd1) == cap;
    assign hdr_bad   = ((len_reg ^ ram_rdata) != CPL_MASK) || (len_reg < MIN_LEN)
                       || (len_reg > BUF8);
    assign short_win = 9'(count_reg) < 9'(len_reg);
    assign chk_bad   = (8'd0 - sum_reg) != chk_reg;
    assign ram_waddr = wrap_addr(head_reg, 8'(count_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HDR1;
                end
            end
            ST_HDR1:
            begin
                state_next = (count_reg < CW'(3)) ? ST_IDLE : ST_HDR2;
            end
            ST_HDR2:
            begin
                state_next = ST_HDR3;
            end
            ST_HDR3:
            begin
                if (hdr_bad)
                begin
                    state_next = ST_HDR1;
                end
                else if (short_win)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (idx_reg == len_reg - 8'd1)
                begin
                    state_next = ST_SUM_END;
                end
            end
            ST_SUM_END:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = chk_bad ? ST_HDR1 : ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = (nres_reg >= NRES_MAX) ? ST_HDR1 : ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    state_next = last_k ? ST_HDR1 : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = 1'b1;
        ram_we   = 1'b0;
        rd_ofs   = LEN_OFS;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_we   = in_valid;
            end
            ST_HDR1:      rd_ofs = LEN_OFS;
            ST_HDR2:      rd_ofs = NLEN_OFS;
            ST_SUM:       rd_ofs = idx_reg;
            ST_EMIT_RD:   rd_ofs = CMD_OFS + k_reg;
            default:      rd_ofs = LEN_OFS;
        endcase
        ram_raddr = wrap_addr(head_reg, rd_ofs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            nres_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SUM);
            if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        nres_reg <= '0;
                        if (count_reg == CW'(BUF_BYTES))
                        begin
                            head_reg <= wrap_addr(head_reg, 8'd1);
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                ST_HDR3:
                begin
                    if (hdr_bad)
                    begin
                        head_reg  <= wrap_addr(head_reg, 8'd1);
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ST_CHECK:
                begin
                    if (chk_bad)
                    begin
                        head_reg  <= wrap_addr(head_reg, 8'd1);
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ST_EMIT_RD:
                begin
                    if (nres_reg >= NRES_MAX)
                    begin
                        head_reg  <= wrap_addr(head_reg, len_reg);
                        count_reg <= count_reg - CW'(len_reg);
                    end
                end
                ST_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    nres_reg      <= nres_reg + NRES_W'(1);
                end
                ST_EMIT_HOLD:
                begin
                    if (out_acc && last_k)
                    begin
                        head_reg  <= wrap_addr(head_reg, len_reg);
                        count_reg <= count_reg - CW'(len_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_HDR2:
            begin
                len_reg <= ram_rdata;
            end
            ST_HDR3:
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            ST_SUM:
            begin
                idx_reg  <= idx_reg + 8'd1;
                pidx_reg <= idx_reg;
            end
            ST_CHECK:
            begin
                k_reg <= '0;
            end
            ST_EMIT_LD:
            begin
                ofrm_addr_reg <= addr_reg;
                ofrm_chk_reg  <= chk_reg;
                obyte_reg     <= ram_rdata;
                olen_reg      <= len_reg[6:0];
                ocap_reg      <= cap[5:0];
                oidx_reg      <= k_reg[4:0];
                otrunc_reg    <= total > PMAX8;
                olast_reg     <= last_k;
            end
            ST_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    k_reg <= k_reg + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
        // sum pipeline, read data arrives in the cycle after its address
        if (pend_reg)
        begin
            if (pidx_reg == 8'd0)
            begin
                addr_reg <= ram_rdata;
            end
            if (pidx_reg == len_reg - 8'd1)
            begin
                chk_reg <= ram_rdata;
            end
            else
            begin
                sum_reg <= sum_reg + ram_rdata;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_addr    = ofrm_addr_reg;
    assign frame_len     = olen_reg;
    assign payload_len   = ocap_reg;
    assign byte_index    = oidx_reg;
    assign payload_byte  = obyte_reg;
    assign frame_check   = ofrm_chk_reg;
    assign truncated     = otrunc_reg;
    assign last_of_frame = olast_reg;

`ifndef ASSERT_OFF
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("result pending while taking requests");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        9'(count_reg) <= BUF9)
        else $error("window count above capacity");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_of_frame |=> !out_valid)
        else $error("result after last of frame");
`endif

endmodule
